/* rtl/dts_pkg.sv */
// shared types and constants for the decimal truncated root block
// depends on nothing; used by decimal_truncated_sqrt
package dts_pkg;

  // field and port widths
  localparam int RADICAND_W  = 64;
  localparam int ROOT_W      = 62;
  localparam int TDATA_IN_W  = 64;
  localparam int TDATA_OUT_W = 64;
  localparam int PLACES_W    = 4;

  // register reset value
  localparam logic [PLACES_W-1:0] PLACES_RESET = 4'd6;

  // parameter defaults
  localparam int INT_BITS_DEF   = 24;
  localparam int FRAC_BITS_DEF  = 40;
  localparam int MAX_PLACES_DEF = 15;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ROOT
  } state_e;

endpackage

/* rtl/decimal_truncated_sqrt.sv */
// decimal truncated root: floor(sqrt(radicand / 2^FRAC_BITS) * 10^places)
// depends on dts_pkg (widths, reset value, state enum)

// Takes one unsigned fixed-point radicand (INT_BITS integer bits, FRAC_BITS
// fraction bits) per transaction and returns floor(sqrt(x) * 10^places),
// exact, with places from the decimal_places register (0 acts as 1, values
// above MAX_PLACES act as MAX_PLACES). The radicand is first scaled by
// 100^places in 2*places multiply-by-ten steps of a shift-and-add unit, the
// fraction bits are dropped, and the root is then formed one bit per cycle by
// a restoring digit recurrence that shifts two radicand bits out and one root
// bit in per step; the last step waits while the previous result is still
// unread. The root is RW bits wide, where RW is 65 with default parameters.
// The block works on one item at a time; a finished result sits in an output
// register, so the next item is taken while it waits. decimal_places is
// written with cfg_we_i; the user must write it only while the block is idle,
// which the block itself does not enforce.
module decimal_truncated_sqrt #(
  parameter int INT_BITS   = dts_pkg::INT_BITS_DEF,
  parameter int FRAC_BITS  = dts_pkg::FRAC_BITS_DEF,
  parameter int MAX_PLACES = dts_pkg::MAX_PLACES_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration write
  input  logic                             cfg_we_i,
  input  logic [dts_pkg::PLACES_W-1:0]     cfg_wdata_i,   // decimal_places
  // input stream
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  input  logic [dts_pkg::TDATA_IN_W-1:0]   s_axis_tdata_i,  // [63:0] radicand
  // output stream
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  output logic [dts_pkg::TDATA_OUT_W-1:0]  m_axis_tdata_o   // [61:0] root_scaled, rest zero
);

  // radicand bits actually used
  localparam int IN_W   = (INT_BITS + FRAC_BITS < dts_pkg::RADICAND_W) ?
                          (INT_BITS + FRAC_BITS) : dts_pkg::RADICAND_W;
  // scaled product: 100 < 2^7, so 7 bits of growth per place
  localparam int PW     = IN_W + 7 * MAX_PLACES;
  // integer part of the scaled value
  localparam int NW     = PW - FRAC_BITS;
  // root bits, radicand shift register and partial remainder widths
  localparam int RW     = (NW + 1) / 2;
  localparam int RAD_W  = 2 * RW;
  localparam int REM_W  = RW + 2;
  localparam int MCNT_W = $clog2(2 * MAX_PLACES + 1);
  localparam int RCNT_W = $clog2(RW + 1);

  dts_pkg::state_e state_q, state_d;

  logic [dts_pkg::PLACES_W-1:0] places_q;
  logic [dts_pkg::PLACES_W-1:0] places_eff;

  logic [MCNT_W-1:0] mul_cnt_q, mul_cnt_d;
  logic [RCNT_W-1:0] root_cnt_q, root_cnt_d;

  logic [PW-1:0]    prod_q, prod_d;
  logic [RAD_W-1:0] rad_q, rad_d;
  logic [REM_W-1:0] rem_q, rem_d;
  logic [RW-1:0]    root_q, root_d;
  logic [dts_pkg::ROOT_W-1:0] out_q, out_d;
  logic             out_valid_q, out_valid_d;

  // sequencer controls
  logic accept;
  logic mul_step;
  logic root_load;
  logic root_step;
  logic root_last;
  logic root_done;

  // digit recurrence signals
  logic [REM_W+1:0] rem_t;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             take;

  // clamp the configured place count into 1..MAX_PLACES
  always_comb begin
    if (places_q == '0) begin
      places_eff = dts_pkg::PLACES_W'(1);
    end else if (places_q > dts_pkg::PLACES_W'(MAX_PLACES)) begin
      places_eff = dts_pkg::PLACES_W'(MAX_PLACES);
    end else begin
      places_eff = places_q;
    end
  end

  assign root_last = (root_cnt_q == RCNT_W'(1));

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      dts_pkg::ST_IDLE: begin
        if (s_axis_tvalid_i) state_d = dts_pkg::ST_MUL;
      end
      dts_pkg::ST_MUL: begin
        if (mul_cnt_q == '0) state_d = dts_pkg::ST_ROOT;
      end
      dts_pkg::ST_ROOT: begin
        if (root_last && (!out_valid_q || m_axis_tready_i)) state_d = dts_pkg::ST_IDLE;
      end
      default: state_d = dts_pkg::ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_axis_tready_o = 1'b0;
    mul_step        = 1'b0;
    root_load       = 1'b0;
    root_step       = 1'b0;
    unique case (state_q)
      dts_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
      end
      dts_pkg::ST_MUL: begin
        mul_step  = (mul_cnt_q != '0);
        root_load = (mul_cnt_q == '0);
      end
      dts_pkg::ST_ROOT: begin
        // hold the last step while the previous result is still pending
        root_step = !(root_last && out_valid_q && !m_axis_tready_i);
      end
      default: begin
        s_axis_tready_o = 1'b0;
      end
    endcase
  end

  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign root_done = root_step && root_last;

  // one recurrence step: bring down two bits, try root*4+1
  assign rem_t = {rem_q, rad_q[RAD_W-1 -: 2]};
  assign trial = (REM_W + 2)'({root_q, 2'b01});
  assign take  = (rem_t >= trial);
  assign diff  = rem_t - trial;

  // datapath next values
  always_comb begin
    prod_d = prod_q;
    rad_d  = rad_q;
    rem_d  = rem_q;
    root_d = root_q;
    out_d  = out_q;
    if (accept) begin
      // drop radicand bits above the fixed-point format
      prod_d = PW'(s_axis_tdata_i[IN_W-1:0]);
    end else if (mul_step) begin
      // times ten
      prod_d = (prod_q << 3) + (prod_q << 1);
    end
    if (root_load) begin
      // integer part of the scaled value
      rad_d  = RAD_W'(prod_q[PW-1:FRAC_BITS]);
      rem_d  = '0;
      root_d = '0;
    end else if (root_step) begin
      rad_d  = rad_q << 2;
      rem_d  = take ? REM_W'(diff) : REM_W'(rem_t);
      root_d = {root_q[RW-2:0], take};
    end
    if (root_done) begin
      out_d = dts_pkg::ROOT_W'(root_d);
    end
  end

  // control next values
  always_comb begin
    mul_cnt_d   = mul_cnt_q;
    root_cnt_d  = root_cnt_q;
    out_valid_d = out_valid_q;
    if (accept) begin
      // two multiply-by-ten steps per place
      mul_cnt_d = MCNT_W'({places_eff, 1'b0});
    end else if (mul_step) begin
      mul_cnt_d = mul_cnt_q - MCNT_W'(1);
    end
    if (root_load) begin
      root_cnt_d = RCNT_W'(RW);
    end else if (root_step) begin
      root_cnt_d = root_cnt_q - RCNT_W'(1);
    end
    if (root_done) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dts_pkg::ST_IDLE;
      places_q    <= dts_pkg::PLACES_RESET;
      mul_cnt_q   <= '0;
      root_cnt_q  <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      mul_cnt_q   <= mul_cnt_d;
      root_cnt_q  <= root_cnt_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) places_q <= cfg_wdata_i;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
    rad_q  <= rad_d;
    rem_q  <= rem_d;
    root_q <= root_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = dts_pkg::TDATA_OUT_W'(out_q);

  // an accepted transaction always starts the scaling phase
  a_accept_to_mul: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> (state_q == dts_pkg::ST_MUL))
    else $error("accepted item did not enter scaling");

  // the root phase always has steps left
  a_root_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dts_pkg::ST_ROOT) |-> (root_cnt_q != '0))
    else $error("root step counter empty during root phase");

  // the scaling count never exceeds two steps per place
  a_mul_cnt: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == dts_pkg::ST_MUL) |-> (mul_cnt_q <= MCNT_W'(2 * MAX_PLACES)))
    else $error("scaling step count out of range");

  // a new result only appears at the end of a root phase
  a_result_source: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> ($past(state_q) == dts_pkg::ST_ROOT))
    else $error("result raised outside the root phase");

endmodule
